// ----- design/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern search block.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PAT_BYTES   = 16;
    localparam int ADDR_W      = 32;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int REG_IDX_W   = 3;

    // register index codes, register i at byte address 8*i
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RESULT_OFFSET  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCAN_BACKWARD  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_START    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_END      = 3'd7;

    localparam logic [15:0] CARE_MASK_RESET      = 16'hFFFF;
    localparam logic [4:0]  PATTERN_LENGTH_RESET = 5'd1;

    typedef struct packed {
        logic [7:0]        byte_value;
        logic [ADDR_W-1:0] byte_address;
        logic              final_byte;
    } in_beat_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_beat_t;

    typedef struct packed {
        logic [63:0]              pattern_low;
        logic [63:0]              pattern_high;
        logic [PAT_BYTES-1:0]     care_mask;
        logic [4:0]               pattern_length;
        logic signed [ADDR_W-1:0] result_offset;
        logic                     scan_backward;
        logic [ADDR_W-1:0]        range_start;
        logic [ADDR_W-1:0]        range_end;
    } cfg_t;

endpackage

// ----- design/mbps_regs.sv -----
// ----------------------------------------------------------------------------
// mbps_regs
// APB register file holding pattern, mask, length, offset, mode and range.
// ----------------------------------------------------------------------------
module mbps_regs
    import mbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_LOW:    cfg_next.pattern_low    = pwdata;
                REG_PATTERN_HIGH:   cfg_next.pattern_high   = pwdata;
                REG_CARE_MASK:      cfg_next.care_mask      = pwdata[15:0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length = pwdata[4:0];
                REG_RESULT_OFFSET:  cfg_next.result_offset  = $signed(pwdata[31:0]);
                REG_SCAN_BACKWARD:  cfg_next.scan_backward  = pwdata[0];
                REG_RANGE_START:    cfg_next.range_start    = pwdata[31:0];
                REG_RANGE_END:      cfg_next.range_end      = pwdata[31:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                <= '0;
            cfg_reg.care_mask      <= CARE_MASK_RESET;
            cfg_reg.pattern_length <= PATTERN_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_LOW:    prdata = cfg_reg.pattern_low;
            REG_PATTERN_HIGH:   prdata = cfg_reg.pattern_high;
            REG_CARE_MASK:      prdata = 64'(cfg_reg.care_mask);
            REG_PATTERN_LENGTH: prdata = 64'(cfg_reg.pattern_length);
            REG_RESULT_OFFSET:  prdata = 64'($unsigned(cfg_reg.result_offset));
            REG_SCAN_BACKWARD:  prdata = 64'(cfg_reg.scan_backward);
            REG_RANGE_START:    prdata = 64'(cfg_reg.range_start);
            REG_RANGE_END:      prdata = 64'(cfg_reg.range_end);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- design/mbps_scan.sv -----
// ----------------------------------------------------------------------------
// mbps_scan
// Byte window, parallel masked compare and match tracking for one scan.
// ----------------------------------------------------------------------------
module mbps_scan
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              step,
    input  in_beat_t          beat,
    output out_beat_t         result
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_MAX);
    localparam logic [4:0]        LEN_MAX  = 5'(PATTERN_MAX);

    logic [7:0]        window_reg [PATTERN_MAX];
    logic [7:0]        window_next[PATTERN_MAX];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_inc;
    logic              have_match_reg;
    logic              have_match_next;
    logic [ADDR_W-1:0] match_pos_reg;
    logic [ADDR_W-1:0] match_pos_next;

    logic [4:0]        len_eff;
    logic [4:0]        k_full;
    logic [3:0]        k;
    logic [127:0]      pattern;
    logic              mismatch;
    logic              full_enough;
    logic [ADDR_W-1:0] cand_pos;
    logic [ADDR_W-1:0] limit;
    logic              in_range;
    logic              hit;
    logic              hm_upd;
    logic [ADDR_W-1:0] pos_upd;

    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    always_comb
    begin
        if (cfg.pattern_length == 5'd0)
            len_eff = 5'd1;
        else if (cfg.pattern_length > LEN_MAX)
            len_eff = LEN_MAX;
        else
            len_eff = cfg.pattern_length;
    end

    // window after this beat shifts in, slot 0 newest
    always_comb
    begin
        window_next[0] = beat.byte_value;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];
    end

    // slot i pairs with pattern byte len-1-i; byte 0 is compared regardless of mask
    always_comb
    begin
        mismatch = 1'b0;
        k_full   = '0;
        k        = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            k_full = len_eff - 5'(i) - 5'd1;
            k      = k_full[3:0];
            if ((5'(i) < len_eff) && ((k == 4'd0) || cfg.care_mask[k]) &&
                (window_next[i] != pattern[{k, 3'b000} +: 8]))
                mismatch = 1'b1;
        end
    end

    assign fill_inc    = (fill_reg < FILL_MAX) ? fill_reg + 1'b1 : fill_reg;
    assign full_enough = 5'(fill_inc) >= len_eff;
    assign cand_pos    = beat.byte_address - ADDR_W'(len_eff - 5'd1);
    assign limit       = cfg.range_end - ADDR_W'(len_eff);

    always_comb
    begin
        if (cfg.scan_backward)
            in_range = (cand_pos >= limit) && (cand_pos <= cfg.range_start);
        else
            in_range = (cand_pos >= cfg.range_start) && (cand_pos < limit);
    end

    assign hit     = full_enough && in_range && !mismatch &&
                     (cfg.scan_backward || !have_match_reg);
    assign hm_upd  = have_match_reg || hit;
    assign pos_upd = hit ? cand_pos : match_pos_reg;

    assign result.found         = hm_upd;
    assign result.match_address = hm_upd ? pos_upd + $unsigned(cfg.result_offset) : '0;

    // a final beat ends the scan and clears the tracking state
    always_comb
    begin
        fill_next       = fill_reg;
        have_match_next = have_match_reg;
        match_pos_next  = match_pos_reg;
        if (step)
        begin
            if (beat.final_byte)
            begin
                fill_next       = '0;
                have_match_next = 1'b0;
                match_pos_next  = '0;
            end
            else
            begin
                fill_next       = fill_inc;
                have_match_next = hm_upd;
                match_pos_next  = pos_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            have_match_reg <= 1'b0;
            match_pos_reg  <= '0;
        end
        else
        begin
            fill_reg       <= fill_next;
            have_match_reg <= have_match_next;
            match_pos_reg  <= match_pos_next;
        end
    end

    // window slots only count toward a hit once the fill count covers them
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
                window_reg[i] <= window_next[i];
        end
    end

endmodule

// ----- design/masked_byte_pattern_search.sv -----
// a final byte accepted into in_reg is registered into out_reg, with out_valid set, once the output register is free
// throughput: one byte per cycle, set by the compare and match update, while final bytes
// find room on the output side; a byte that is not final never waits on the output side
// reset: rst_n clears the fill count, match state, both valid flags and the registers
// to their defaults; the byte window is not reset and only counts toward a hit once refilled
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Streams memory bytes through a window and reports the kept masked match.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    in_beat_t  in_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_beat_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_beat_t result;
    logic      out_free;
    logic      step;
    logic      take;

    mbps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbps_scan #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .beat   (in_reg),
        .result (result)
    );

    // only a final beat needs room in the output register
    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && (!in_reg.final_byte || out_free);
    assign in_ready = !in_valid_reg || step;
    assign take     = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step && in_reg.final_byte)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= in_data;
        if (step && in_reg.final_byte)
            out_reg <= result;
    end

endmodule

// ----- bench/mbps_check_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbps_check_pkg
// Result tracker for the masked byte pattern search bench: keeps its own copy
// of the search registers and scan state, predicts the report that each final
// beat causes and compares it with what the block returns.
// ----------------------------------------------------------------------------
package mbps_check_pkg;
    import mbps_pkg::*;

    class scan_result_tracker;
        cfg_t        cfg;
        logic [7:0]  window [PAT_BYTES];
        int unsigned fill;
        bit          have_match;
        logic [31:0] match_pos;
        out_beat_t   pending_reports [$];
        int unsigned errors;

        function new();
            cfg = '0;
            cfg.care_mask = CARE_MASK_RESET;
            cfg.pattern_length = PATTERN_LENGTH_RESET;
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            for (int i = 0; i < PAT_BYTES; i++)
            begin
                window[i] = 8'h00;
            end
            fill = 0;
            have_match = 1'b0;
            match_pos = '0;
        endfunction

        function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
            case (idx)
                REG_PATTERN_LOW:    cfg.pattern_low = value;
                REG_PATTERN_HIGH:   cfg.pattern_high = value;
                REG_CARE_MASK:      cfg.care_mask = value[15:0];
                REG_PATTERN_LENGTH: cfg.pattern_length = value[4:0];
                REG_RESULT_OFFSET:  cfg.result_offset = value[31:0];
                REG_SCAN_BACKWARD:  cfg.scan_backward = value[0];
                REG_RANGE_START:    cfg.range_start = value[31:0];
                REG_RANGE_END:      cfg.range_end = value[31:0];
                default:            ;
            endcase
        endfunction

        // zero behaves as one, anything past the window depth is clipped
        function int unsigned active_length();
            if (cfg.pattern_length == 0)
                return 1;
            if (cfg.pattern_length > PAT_BYTES)
                return PAT_BYTES;
            return cfg.pattern_length;
        endfunction

        function logic [7:0] pattern_byte(input int unsigned k);
            if (k < 8)
                return cfg.pattern_low[8*k +: 8];
            return cfg.pattern_high[8*(k-8) +: 8];
        endfunction

        // the first pattern byte is compared whatever the mask holds
        function bit byte_compared(input int unsigned k);
            return (k == 0) || cfg.care_mask[k];
        endfunction

        function void note_byte(input in_beat_t b);
            int unsigned len;
            logic [31:0] p;
            logic [31:0] lim;
            bit          hit;
            out_beat_t   report;
            len = active_length();
            for (int i = PAT_BYTES - 1; i > 0; i--)
            begin
                window[i] = window[i-1];
            end
            window[0] = b.byte_value;
            if (fill < PAT_BYTES)
                fill++;
            if (fill >= len)
            begin
                p = b.byte_address - (len - 1);
                lim = cfg.range_end - len;
                if (cfg.scan_backward)
                    hit = (p >= lim) && (p <= cfg.range_start);
                else
                    hit = (p >= cfg.range_start) && (p < lim);
                for (int k = 0; k < len; k++)
                begin
                    if (byte_compared(k) && window[len-1-k] != pattern_byte(k))
                        hit = 1'b0;
                end
                if (hit && (cfg.scan_backward || !have_match))
                begin
                    have_match = 1'b1;
                    match_pos = p;
                end
            end
            if (b.final_byte)
            begin
                report.found = have_match;
                report.match_address = have_match ? match_pos + cfg.result_offset : '0;
                pending_reports.push_back(report);
                clear_scan();
            end
        endfunction

        function void check_result(input out_beat_t got);
            out_beat_t want;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with none pending: found=%0b match_address=%h",
                         $time, got.found, got.match_address);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found mismatch: expected %0b actual %0b",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.match_address !== want.match_address)
            begin
                $display("%0t: match_address mismatch: expected %h actual %h",
                         $time, want.match_address, got.match_address);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for masked_byte_pattern_search: a few directed scans on the corner
// cases, then random scans with planted pattern copies under changing search
// registers, random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import mbps_pkg::*;
    import mbps_check_pkg::*;

    localparam int RUN_LIMIT    = 500000;
    localparam int RANDOM_BYTES = 1600;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_beat_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_beat_t             out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    scan_result_tracker tracker;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_len = 0;
    int unsigned hold_cnt = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;

    masked_byte_pattern_search dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // output side: a requested hold-off first, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_cnt < hold_len)
        begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_byte(in_data);
            if (out_valid && out_ready)
                tracker.check_result(out_data);
        end
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic in_beat_t make_beat(input logic [7:0] v, input logic [31:0] a,
                                           input logic f);
        in_beat_t b;
        b.byte_value = v;
        b.byte_address = a;
        b.final_byte = f;
        return b;
    endfunction

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tracker.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_byte(input in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // a byte that is not final may still be in flight when the last report lands
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_setup(input logic [31:0] region);
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [15:0] mask;
        logic [4:0]  plen;
        logic [31:0] offs;
        logic [31:0] rs;
        logic [31:0] re;
        pat_lo = {$urandom, $urandom};
        pat_hi = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       mask = 16'hFFFF;
            1:       mask = 16'h0000;
            default: mask = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0:       plen = 5'd0;
            1:       plen = 5'($urandom_range(31, 17));
            2:       plen = 5'd16;
            default: plen = 5'($urandom_range(16, 1));
        endcase
        case ($urandom_range(7))
            0:       offs = 32'h0000_0000;
            1:       offs = 32'h7FFF_FFFF;
            2:       offs = 32'h8000_0000;
            3:       offs = 32'hFFFF_FFFF;
            default: offs = $urandom;
        endcase
        case ($urandom_range(11))
            0:
            begin
                rs = 32'h0;
                re = 32'h0;
            end
            1:
            begin
                rs = 32'hFFFF_FFFF;
                re = 32'hFFFF_FFFF;
            end
            2:
            begin
                rs = 32'h0;
                re = 32'hFFFF_FFFF;
            end
            3:
            begin
                rs = 32'hFFFF_FFFF;
                re = 32'h0;
            end
            default:
            begin
                rs = region + $urandom_range(40) - 10;
                re = region + $urandom_range(80);
            end
        endcase
        cfg_write(REG_PATTERN_LOW, pat_lo);
        cfg_write(REG_PATTERN_HIGH, pat_hi);
        cfg_write(REG_CARE_MASK, 64'(mask));
        cfg_write(REG_PATTERN_LENGTH, 64'(plen));
        cfg_write(REG_RESULT_OFFSET, 64'(offs));
        cfg_write(REG_SCAN_BACKWARD, 64'($urandom_range(1)));
        cfg_write(REG_RANGE_START, 64'(rs));
        cfg_write(REG_RANGE_END, 64'(re));
    endtask

    // random bytes with up to three copies of the pattern dropped in
    task automatic run_scan(input logic [31:0] base, input int unsigned count,
                            input bit scatter);
        logic [7:0]  data [];
        int unsigned len;
        int unsigned at;
        logic [31:0] addr;
        data = new[count];
        for (int i = 0; i < count; i++)
        begin
            data[i] = 8'($urandom);
        end
        len = tracker.active_length();
        if (count >= len)
        begin
            repeat ($urandom_range(3))
            begin
                at = $urandom_range(count - len);
                for (int k = 0; k < len; k++)
                begin
                    if (tracker.byte_compared(k) || $urandom_range(1))
                        data[at+k] = tracker.pattern_byte(k);
                end
            end
        end
        for (int i = 0; i < count; i++)
        begin
            addr = base + i;
            if (scatter && $urandom_range(3) == 0)
                addr = $urandom;
            send_byte(make_beat(data[i], addr, i == count - 1));
        end
        bytes_sent += count;
    endtask

    initial
    begin
        logic [31:0] region;
        int unsigned phase;
        int unsigned count;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: one-byte zero pattern over nearly the whole space
        send_byte(make_beat(8'h00, 32'h0000_0000, 1'b1));
        send_byte(make_beat(8'hFF, 32'hFFFF_FFFF, 1'b1));
        wait_idle();

        // length zero, empty care mask: first byte still compared, first hit kept
        cfg_write(REG_PATTERN_LOW, 64'h5A);
        cfg_write(REG_CARE_MASK, 64'h0);
        cfg_write(REG_PATTERN_LENGTH, 64'h0);
        cfg_write(REG_RESULT_OFFSET, 64'h7FFF_FFFF);
        cfg_write(REG_RANGE_START, 64'h10);
        cfg_write(REG_RANGE_END, 64'h20);
        send_byte(make_beat(8'h5A, 32'h0F, 1'b0));
        send_byte(make_beat(8'h5B, 32'h10, 1'b0));
        send_byte(make_beat(8'h5A, 32'h11, 1'b0));
        send_byte(make_beat(8'h5A, 32'h12, 1'b1));
        wait_idle();

        // oversized length, backward, addresses and result wrapping past zero
        cfg_write(REG_PATTERN_LOW, 64'h8877_6655_4433_2211);
        cfg_write(REG_PATTERN_HIGH, 64'h00FF_EEDD_CCBB_AA99);
        cfg_write(REG_CARE_MASK, 64'hFFFF);
        cfg_write(REG_PATTERN_LENGTH, 64'd31);
        cfg_write(REG_RESULT_OFFSET, 64'h10);
        cfg_write(REG_SCAN_BACKWARD, 64'h1);
        cfg_write(REG_RANGE_START, 64'hFFFF_FFFF);
        cfg_write(REG_RANGE_END, 64'h8);
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            send_byte(make_beat(tracker.pattern_byte(k), 32'hFFFF_FFF8 + k,
                                k == PAT_BYTES - 1));
        end
        wait_idle();

        phase = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            case ($urandom_range(7))
                0:       region = 32'h0000_0000;
                1:       region = 32'hFFFF_FFE0;
                default: region = $urandom;
            endcase
            random_setup(region);
            if (phase == 4)
            begin
                // output held off while one-beat scans keep coming
                hold_len = hold_cnt + 150;
                repeat (40) run_scan(region + $urandom_range(40) - 12, 1, 1'b0);
            end
            repeat ($urandom_range(12, 4))
            begin
                if ($urandom_range(9) == 0)
                    count = $urandom_range(48, 20);
                else
                    count = $urandom_range(20, 1);
                run_scan(region + $urandom_range(40) - 12, count, $urandom_range(9) == 0);
            end
            wait_idle();
            phase++;
        end

        if (tracker.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
